@@ src/dsma_pkg.sv @@
// Shared types and constants for the dust sensor moving-average block.
// No dependencies.
`default_nettype none

package dsma_pkg;

  // Input word: one converter result as two bytes.
  typedef struct packed {
    logic [7:0] adc_high;
    logic [7:0] adc_low;
  } in_word_t;

  // Result word.
  typedef struct packed {
    logic [11:0] mean_level;
    logic        under_threshold;
    logic [9:0]  density;
    logic        saturated;
    logic [5:0]  hundreds_char;
    logic [5:0]  tens_char;
    logic [5:0]  ones_char;
  } out_word_t;

  localparam int unsigned PROD_W = 29;

  localparam logic [11:0]       THRESH_RESET = 12'd435;
  // density = floor((mean*33000 - 14336000) / (7 * 2^14))
  localparam logic [15:0]       SCALE_NUM    = 16'd33000;
  localparam logic [PROD_W-1:0] OFFSET_NUM   = 29'd14336000;
  localparam int unsigned       DEN_SHIFT    = 14;
  // (diff >> 14) at or above this gives a quotient above 999
  localparam logic [14:0]       SAT_LIMIT    = 15'd7000;
  // ceil(2^16 / 7), exact for dividends below SAT_LIMIT
  localparam logic [15:0]       RECIP_7      = 16'd9363;
  // floor(d/100) = (d*41) >> 12 for d < 1000
  localparam logic [15:0]       RECIP_100    = 16'd41;
  // floor(r/10) = (r*205) >> 11 for r < 100
  localparam logic [15:0]       RECIP_10     = 16'd205;
  localparam logic [9:0]        DENSITY_MAX  = 10'd999;
  localparam logic [5:0]        ASCII_ZERO   = 6'd48;

endpackage

`default_nettype wire

@@ src/dust_sensor_moving_average.sv @@
// Moving-average dust density: sample ring, iterative mean, shared multiplier scaling.
// Depends on dsma_pkg.
//
// Sequence: after a word is accepted, the ring is summed entry by entry, then the mean is
//   multiplied out, followed by the threshold compare, scaling and digit steps; under
//   threshold the scaling and digit steps are skipped.
// Flow: in_ready is high only in idle, so no new word is taken until the last result has
//   been loaded into the output register. An untaken result holds the next one in its
//   last step.
// Reset (rst, synchronous): ring and write slot cleared, threshold 435, no result.
`default_nettype none

module dust_sensor_moving_average #(
  parameter int unsigned WINDOW = 10
) (
  input  wire                clk,
  input  wire                rst,
  input  wire                in_valid,
  output logic               in_ready,
  input  dsma_pkg::in_word_t in_data,
  output logic               out_valid,
  input  wire                out_ready,
  output dsma_pkg::out_word_t out_data,
  input  wire                cfg_valid,
  output logic               cfg_ready,
  input  wire  [11:0]        cfg_data
);

  // Ring index width and ring sum width (WINDOW * 4095 fits).
  localparam int unsigned SW    = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int unsigned SUM_W = 12 + $clog2(WINDOW);
  // floor(sum / WINDOW) = (sum * MEAN_RECIP) >> MEAN_SHIFT, exact for any
  // sum below WINDOW * 4096 with WINDOW up to 16.
  localparam int unsigned MEAN_SHIFT = 20;
  localparam logic [20:0] MEAN_RECIP = 21'((2 ** MEAN_SHIFT + WINDOW - 1) / WINDOW);
  localparam int unsigned MUL_W      = 37;

  typedef enum logic [3:0] {
    S_IDLE,   // wait for a word
    S_SUM,    // add one ring entry per cycle
    S_MEAN,   // sum * reciprocal of WINDOW
    S_CHK,    // threshold compare, start mean * 33000
    S_RECIP,  // offset, shift by 2^14, start divide by 7
    S_HUND,   // clamp density, start hundreds digit
    S_TENS,   // remainder below 100, start tens digit
    S_DIGS,   // tens and ones digits
    S_FIN     // load output register
  } state_t;

  state_t              state;
  logic [11:0]         threshold;
  logic [11:0]         ring [WINDOW];
  logic [SW-1:0]       slot;
  logic [SW-1:0]       idx;
  logic [SUM_W-1:0]    acc;       // running ring sum
  logic [11:0]         mean;
  logic                under;
  logic                sat;
  logic [9:0]          dens;
  logic [3:0]          hund;
  logic [6:0]          below_100;
  logic [3:0]          tens;
  logic [3:0]          ones;
  logic [MUL_W-1:0]    prod;

  // Shared multiplier operands, chosen by state.
  logic [15:0]         mul_a;
  logic [20:0]         mul_b;
  logic [MUL_W-1:0]    prod_next;

  // Scaling helpers.
  logic [11:0]         mean_now;
  logic [dsma_pkg::PROD_W-1:0] diff;
  logic [14:0]         scaled;
  logic [9:0]          dens_next;
  logic [9:0]          hund_x100;
  logic [6:0]          tens_x10;

  logic [SUM_W-1:0]    sum_next;
  logic                out_load;

  assign in_ready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;

  assign sum_next = acc + SUM_W'(ring[idx]);
  assign mean_now = prod[MEAN_SHIFT +: 12];
  assign out_load = (state == S_FIN) && (!out_valid || out_ready);

  assign diff      = (prod[dsma_pkg::PROD_W-1:0] > dsma_pkg::OFFSET_NUM)
                   ? (prod[dsma_pkg::PROD_W-1:0] - dsma_pkg::OFFSET_NUM) : '0;
  assign scaled    = diff[dsma_pkg::DEN_SHIFT +: 15];
  assign dens_next = sat ? dsma_pkg::DENSITY_MAX : prod[25:16];
  assign hund_x100 = 10'(prod[15:12]) * 10'd100;
  assign tens_x10  = 7'(prod[14:11]) * 7'd10;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      S_MEAN: begin
        mul_a = 16'(acc);
        mul_b = MEAN_RECIP;
      end
      S_CHK: begin
        mul_a = 16'(mean_now);
        mul_b = 21'(dsma_pkg::SCALE_NUM);
      end
      S_RECIP: begin
        mul_a = 16'(scaled[12:0]);   // only used when below SAT_LIMIT
        mul_b = 21'(dsma_pkg::RECIP_7);
      end
      S_HUND: begin
        mul_a = 16'(dens_next);
        mul_b = 21'(dsma_pkg::RECIP_100);
      end
      S_TENS: begin
        mul_a = 16'(7'(dens - hund_x100));
        mul_b = 21'(dsma_pkg::RECIP_10);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    prod_next = MUL_W'(mul_a) * MUL_W'(mul_b);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      threshold <= dsma_pkg::THRESH_RESET;
      slot      <= '0;
      idx       <= '0;
      out_valid <= 1'b0;
      for (int i = 0; i < WINDOW; i++) begin
        ring[i] <= '0;
      end
    end else begin
      if (cfg_valid) begin
        threshold <= cfg_data;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      prod <= prod_next;

      case (state)
        S_IDLE: begin
          if (in_valid) begin
            ring[slot] <= {in_data.adc_high, in_data.adc_low[7:4]};
            slot       <= (slot == SW'(WINDOW - 1)) ? '0 : slot + 1'b1;
            idx        <= '0;
            acc        <= '0;
            state      <= S_SUM;
          end
        end
        S_SUM: begin
          acc <= sum_next;
          idx <= idx + 1'b1;
          if (idx == SW'(WINDOW - 1)) begin
            state <= S_MEAN;
          end
        end
        S_MEAN: begin
          state <= S_CHK;
        end
        S_CHK: begin
          mean  <= mean_now;
          under <= (mean_now < threshold);
          state <= (mean_now < threshold) ? S_FIN : S_RECIP;
        end
        S_RECIP: begin
          sat   <= (scaled >= dsma_pkg::SAT_LIMIT);
          state <= S_HUND;
        end
        S_HUND: begin
          dens  <= dens_next;
          state <= S_TENS;
        end
        S_TENS: begin
          hund      <= prod[15:12];
          below_100 <= 7'(dens - hund_x100);
          state     <= S_DIGS;
        end
        S_DIGS: begin
          tens  <= prod[14:11];
          ones  <= 4'(below_100 - tens_x10);
          state <= S_FIN;
        end
        S_FIN: begin
          // Hold until the output register is free.
          if (out_load) begin
            out_data.mean_level      <= mean;
            out_data.under_threshold <= under;
            if (under) begin
              out_data.density       <= '0;
              out_data.saturated     <= 1'b0;
              out_data.hundreds_char <= '0;
              out_data.tens_char     <= '0;
              out_data.ones_char     <= '0;
            end else begin
              out_data.density       <= dens;
              out_data.saturated     <= sat;
              out_data.hundreds_char <= dsma_pkg::ASCII_ZERO + 6'(hund);
              out_data.tens_char     <= dsma_pkg::ASCII_ZERO + 6'(tens);
              out_data.ones_char     <= dsma_pkg::ASCII_ZERO + 6'(ones);
            end
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

@@ src/dsma_checker.sv @@
// Port-level checks for the dust sensor moving-average block, bound to the top level.
// Depends on dsma_pkg and dust_sensor_moving_average.
`default_nettype none

module dsma_checker (
  input wire                 clk,
  input wire                 rst,
  input wire                 in_valid,
  input wire                 in_ready,
  input wire                 out_valid,
  input wire                 out_ready,
  input dsma_pkg::out_word_t out_data
);

  // A held result word keeps its value.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result word changed while stalled");

  // Busy after taking a word.
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("word accepted while busy");

  // Under threshold zeroes density, saturation, hundreds and ones digits.
  a_under_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.under_threshold |->
      out_data.density == 10'd0 && !out_data.saturated &&
      out_data.hundreds_char == 6'd0 && out_data.ones_char == 6'd0)
    else $error("density fields set under threshold");

  // Saturation reads as 999.
  a_sat_999: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.saturated |->
      out_data.density == dsma_pkg::DENSITY_MAX &&
      out_data.hundreds_char == 6'd57 && out_data.tens_char == 6'd57 &&
      out_data.ones_char == 6'd57)
    else $error("saturated result is not 999");

  // No result straight out of reset.
  a_reset: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind dust_sensor_moving_average dsma_checker u_dsma_checker (.*);

`default_nettype wire
